// ===== sv/bounded_stack_with_sort_unit_assert.svh =====
// Assertion macros for the bounded stack with sort unit.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef BOUNDED_STACK_WITH_SORT_UNIT_ASSERT_SVH
`define BOUNDED_STACK_WITH_SORT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSWS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsws_pkg.sv =====
// Shared types and constants for the bounded stack with sort unit.
// No dependencies; used by the controller, the datapath and the top level.
package bsws_pkg;

	localparam int WORD_W = 32;
	localparam int ACT_W  = 3;
	localparam int POS_W  = 6;

	// Action codes carried by an input beat.
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH  = 3'd0,
		ACT_POP   = 3'd1,
		ACT_READ  = 3'd2,
		ACT_FIND  = 3'd3,
		ACT_SORT  = 3'd4,
		ACT_CHECK = 3'd5
	} act_t;

	// Datapath operations issued by the controller.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_PUSH,
		OP_POP,
		OP_READ,
		OP_DATA_OUT,
		OP_FIND_INIT,
		OP_FIND_STEP,
		OP_CHECK_INIT,
		OP_CHECK_FIRST,
		OP_CHECK_STEP,
		OP_SORT_INIT,
		OP_SORT_RD,
		OP_SORT_KEY,
		OP_SORT_CMP,
		OP_SORT_PLACE,
		OP_BAD_OUT
	} op_t;

	// Command from controller to datapath: an operation and a finish flag
	// that loads the result registers.
	typedef struct packed {
		op_t  op;
		logic fin;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic le1;
		logic pos_ok;
		logic match;
		logic at_end;
		logic desc;
		logic shift;
		logic j_one;
		logic last_i;
	} status_t;

endpackage

// ===== sv/bsws_ctrl.sv =====
// Controller state machine for the bounded stack with sort unit.
// Depends on bsws_pkg for action codes, commands and status.
module bsws_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bsws_pkg::ACT_W-1:0]   action,
	input  bsws_pkg::status_t            st,
	output bsws_pkg::cmd_t               cmd,
	output logic                         busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_POP,
		S_READ,
		S_DATA_OUT,
		S_FIND_INIT,
		S_FIND_STEP,
		S_CHECK_INIT,
		S_CHECK_FIRST,
		S_CHECK_STEP,
		S_SORT_INIT,
		S_SORT_RD,
		S_SORT_KEY,
		S_SORT_CMP,
		S_SORT_PLACE,
		S_BAD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd.op  = bsws_pkg::OP_NONE;
		cmd.fin = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = bsws_pkg::OP_CAPTURE;
					unique case (action)
						bsws_pkg::ACT_PUSH:  state_d = S_PUSH;
						bsws_pkg::ACT_POP:   state_d = S_POP;
						bsws_pkg::ACT_READ:  state_d = S_READ;
						bsws_pkg::ACT_FIND:  state_d = S_FIND_INIT;
						bsws_pkg::ACT_SORT:  state_d = S_SORT_INIT;
						bsws_pkg::ACT_CHECK: state_d = S_CHECK_INIT;
						default:             state_d = S_BAD;
					endcase
				end
			end
			S_PUSH: begin
				cmd.op  = bsws_pkg::OP_PUSH;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				cmd.op = bsws_pkg::OP_POP;
				if (st.empty) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DATA_OUT;
				end
			end
			S_READ: begin
				cmd.op = bsws_pkg::OP_READ;
				if (!st.pos_ok) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DATA_OUT;
				end
			end
			S_DATA_OUT: begin
				cmd.op  = bsws_pkg::OP_DATA_OUT;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			S_FIND_INIT: begin
				cmd.op = bsws_pkg::OP_FIND_INIT;
				if (st.empty) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_FIND_STEP;
				end
			end
			S_FIND_STEP: begin
				cmd.op = bsws_pkg::OP_FIND_STEP;
				if (st.match || st.at_end) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CHECK_INIT: begin
				cmd.op = bsws_pkg::OP_CHECK_INIT;
				if (st.le1) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_CHECK_FIRST;
				end
			end
			S_CHECK_FIRST: begin
				cmd.op  = bsws_pkg::OP_CHECK_FIRST;
				state_d = S_CHECK_STEP;
			end
			S_CHECK_STEP: begin
				cmd.op = bsws_pkg::OP_CHECK_STEP;
				if (st.desc || st.at_end) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SORT_INIT: begin
				cmd.op = bsws_pkg::OP_SORT_INIT;
				if (st.le1) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SORT_RD;
				end
			end
			S_SORT_RD: begin
				cmd.op  = bsws_pkg::OP_SORT_RD;
				state_d = S_SORT_KEY;
			end
			S_SORT_KEY: begin
				cmd.op  = bsws_pkg::OP_SORT_KEY;
				state_d = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				cmd.op = bsws_pkg::OP_SORT_CMP;
				if (st.shift) begin
					if (st.j_one) begin
						state_d = S_SORT_PLACE;
					end
				end else if (st.last_i) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SORT_RD;
				end
			end
			S_SORT_PLACE: begin
				cmd.op = bsws_pkg::OP_SORT_PLACE;
				if (st.last_i) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SORT_RD;
				end
			end
			S_BAD: begin
				cmd.op  = bsws_pkg::OP_BAD_OUT;
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and registered busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// ===== sv/bsws_datapath.sv =====
// Datapath for the bounded stack with sort unit: entry memory, count,
// walk indexes, sort key and result registers. Depends on bsws_pkg.
module bsws_datapath #(
	parameter int CAPACITY = 64,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bsws_pkg::cmd_t                      cmd,
	input  logic signed [bsws_pkg::WORD_W-1:0]  value,
	input  logic [bsws_pkg::POS_W-1:0]          position,
	output bsws_pkg::status_t                   st,
	output logic                                done,
	output logic                                ok,
	output logic signed [bsws_pkg::WORD_W-1:0]  data,
	output logic [AW-1:0]                       found_index,
	output logic [CW-1:0]                       count,
	output logic                                in_order
);

	localparam int PCW = (CW > bsws_pkg::POS_W) ? CW : bsws_pkg::POS_W;

	logic signed [bsws_pkg::WORD_W-1:0] mem_q [CAPACITY];
	logic signed [bsws_pkg::WORD_W-1:0] rd_q;
	logic signed [bsws_pkg::WORD_W-1:0] val_q;
	logic signed [bsws_pkg::WORD_W-1:0] key_q;
	logic signed [bsws_pkg::WORD_W-1:0] prev_q;
	logic [bsws_pkg::POS_W-1:0]         pos_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      i_q;
	logic [CW-1:0]                      j_q;

	logic                               done_q;
	logic                               ok_q;
	logic signed [bsws_pkg::WORD_W-1:0] data_q;
	logic [AW-1:0]                      found_q;
	logic                               in_order_q;

	logic [AW-1:0]                      raddr;
	logic                               we;
	logic [AW-1:0]                      waddr;
	logic signed [bsws_pkg::WORD_W-1:0] wdata;

	logic                               res_ok;
	logic signed [bsws_pkg::WORD_W-1:0] res_data;
	logic [AW-1:0]                      res_found;
	logic                               res_in_order;

	// Status flags for the controller.
	always_comb begin
		st.empty  = (count_q == '0);
		st.full   = (count_q == CW'(CAPACITY));
		st.le1    = (count_q <= CW'(1));
		st.pos_ok = (PCW'(pos_q) < PCW'(count_q));
		st.match  = (rd_q == val_q);
		st.at_end = (i_q == count_q);
		st.desc   = (prev_q > rd_q);
		st.shift  = (rd_q > key_q);
		st.j_one  = (j_q == CW'(1));
		st.last_i = ({1'b0, i_q} + (CW + 1)'(1) == {1'b0, count_q});
	end

	// Memory address and write decode.
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = AW'(j_q);
		wdata = key_q;
		case (cmd.op)
			bsws_pkg::OP_PUSH: begin
				we    = !st.full;
				waddr = AW'(count_q);
				wdata = val_q;
			end
			bsws_pkg::OP_POP:         raddr = AW'(count_q - CW'(1));
			bsws_pkg::OP_READ:        raddr = AW'(pos_q);
			bsws_pkg::OP_FIND_STEP,
			bsws_pkg::OP_CHECK_FIRST,
			bsws_pkg::OP_CHECK_STEP,
			bsws_pkg::OP_SORT_RD:     raddr = AW'(i_q);
			bsws_pkg::OP_SORT_KEY:    raddr = AW'(j_q - CW'(1));
			bsws_pkg::OP_SORT_CMP: begin
				we = 1'b1;
				if (st.shift) begin
					wdata = rd_q;
					raddr = AW'(j_q - CW'(2));
				end
			end
			bsws_pkg::OP_SORT_PLACE:  we = 1'b1;
			default:                  raddr = '0;
		endcase
	end

	// Result fields for a finishing command.
	always_comb begin
		res_ok       = 1'b0;
		res_data     = '0;
		res_found    = '0;
		res_in_order = 1'b0;
		case (cmd.op)
			bsws_pkg::OP_PUSH:       res_ok = !st.full;
			bsws_pkg::OP_DATA_OUT: begin
				res_ok   = 1'b1;
				res_data = rd_q;
			end
			bsws_pkg::OP_FIND_STEP: begin
				res_ok = st.match;
				if (st.match) begin
					res_found = AW'(i_q - CW'(1));
				end
			end
			bsws_pkg::OP_CHECK_INIT: begin
				res_ok       = 1'b1;
				res_in_order = 1'b1;
			end
			bsws_pkg::OP_CHECK_STEP: begin
				res_ok       = 1'b1;
				res_in_order = !st.desc;
			end
			bsws_pkg::OP_SORT_INIT,
			bsws_pkg::OP_SORT_CMP,
			bsws_pkg::OP_SORT_PLACE: res_ok = 1'b1;
			default:                 res_ok = 1'b0;
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// Operands, walk indexes and sort key.
	always_ff @(posedge clk) begin
		case (cmd.op)
			bsws_pkg::OP_CAPTURE: begin
				val_q <= value;
				pos_q <= position;
			end
			bsws_pkg::OP_FIND_INIT,
			bsws_pkg::OP_CHECK_INIT,
			bsws_pkg::OP_SORT_INIT:  i_q <= CW'(1);
			bsws_pkg::OP_FIND_STEP:  i_q <= i_q + CW'(1);
			bsws_pkg::OP_CHECK_FIRST,
			bsws_pkg::OP_CHECK_STEP: begin
				prev_q <= rd_q;
				i_q    <= i_q + CW'(1);
			end
			bsws_pkg::OP_SORT_RD:    j_q <= i_q;
			bsws_pkg::OP_SORT_KEY:   key_q <= rd_q;
			bsws_pkg::OP_SORT_CMP: begin
				if (st.shift) begin
					j_q <= j_q - CW'(1);
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			bsws_pkg::OP_SORT_PLACE: i_q <= i_q + CW'(1);
			default: begin
			end
		endcase
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == bsws_pkg::OP_PUSH && !st.full) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.op == bsws_pkg::OP_POP && !st.empty) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	// Result payload, loaded when a command finishes.
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			ok_q       <= res_ok;
			data_q     <= res_data;
			found_q    <= res_found;
			in_order_q <= res_in_order;
		end
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign data        = data_q;
	assign found_index = found_q;
	assign count       = count_q;
	assign in_order    = in_order_q;

endmodule

// ===== sv/bounded_stack_with_sort_unit.sv =====
// Top level of the bounded stack with sort unit.
// Depends on bsws_pkg, bsws_ctrl, bsws_datapath and the assertion header.
//
// A command beat (action, value, position) is taken at a rising edge where
// start is high and busy is low. Exactly one result beat follows: done is
// high for one cycle with ok, data, found_index, count and in_order, and the
// beat is taken at the edge that ends that cycle; the receiver cannot stall.
// Busy drops in the cycle where done shows, so the next command can be taken
// at the same edge as the result.
// No new command is taken until the result beat of the last one. Push and a
// bad action code need no walk; pop on an empty stack and read out of range
// finish without the data-out step. Find stops at a match or at the end,
// check at the first descending pair or at the end. Sort ends without a walk
// when count <= 1, else it inserts each entry from the second on, moving the
// larger entries up one by one. Walks use the single registered read port.
// Reset clears the count, the controller and the result strobe; the entry
// memory is not cleared; entries at or above the count never reach a result.
module bounded_stack_with_sort_unit #(
	parameter int CAPACITY = 64,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [bsws_pkg::ACT_W-1:0]          action,
	input  logic signed [bsws_pkg::WORD_W-1:0]  value,
	input  logic [bsws_pkg::POS_W-1:0]          position,
	output logic                                done,
	output logic                                ok,
	output logic signed [bsws_pkg::WORD_W-1:0]  data,
	output logic [AW-1:0]                       found_index,
	output logic [CW-1:0]                       count,
	output logic                                in_order
);

	bsws_pkg::cmd_t    cmd;
	bsws_pkg::status_t st;

	// Controller.
	bsws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	bsws_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.position    (position),
		.st          (st),
		.done        (done),
		.ok          (ok),
		.data        (data),
		.found_index (found_index),
		.count       (count),
		.in_order    (in_order)
	);

	`include "bounded_stack_with_sort_unit_assert.svh"

	// Checks on count bound and the busy and done sequencing.
	`BSWS_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY), "count above capacity")
	`BSWS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "no busy after accepted beat")
	`BSWS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
	`BSWS_ASSERT_NXT(a_done_single, done, !done, "two results in a row")

endmodule
